// ===== rtl/global_tolerance_color_fill_core_defines.svh =====
// ----------------------------------------------------------------------------
// Global tolerance color fill - assertion macros
// Shared same-cycle and next-cycle implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef GLOBAL_TOLERANCE_COLOR_FILL_CORE_DEFINES_SVH
`define GLOBAL_TOLERANCE_COLOR_FILL_CORE_DEFINES_SVH

// same-cycle implication, reset-gated
`define GTCF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gtcf assertion failed");

// next-cycle implication, reset-gated
`define GTCF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gtcf assertion failed");

`endif

// ===== rtl/gtcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtcf_pkg
// Shared types, register codes and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package gtcf_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_COLOR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE_MODE = 2'd3;

	localparam int unsigned CH_BLUE  = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_RED   = 2;
	localparam int unsigned CH_ALPHA = 3;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

	// four packed 8-bit channels, blue in [0]
	typedef logic [3:0][7:0] pixel_t;

	// per-stage advance enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

	// exact floor(x / 255) for x <= 65279
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

// ===== rtl/gtcf_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtcf_pipe
// Three-stage pixel datapath: products, distance test and divide, result mux.
// ----------------------------------------------------------------------------
module gtcf_pipe import gtcf_pkg::*; (
	input  logic     clk,
	input  pipe_en_t en,
	input  pixel_t   pix,
	input  logic     selected,
	input  pixel_t   target,
	input  pixel_t   fill,
	input  logic [7:0] tol,
	input  logic     overwrite,
	output pixel_t   res,
	output logic     filled
);

	// stage 1: squared differences and blend numerators
	pixel_t      px_s1;
	logic        sel_s1;
	logic [15:0] sqd_s1 [4];
	logic [15:0] num_s1 [4];

	logic [7:0]  ia;
	logic [7:0]  ad [4];
	logic [15:0] sqd_d [4];
	logic [15:0] num_d [4];

	assign ia = ALPHA_OPAQUE - fill[CH_ALPHA];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ad[k]    = (pix[k] >= target[k]) ? (pix[k] - target[k]) : (target[k] - pix[k]);
			sqd_d[k] = ad[k] * ad[k];
		end
		for (int k = 0; k < 3; k++) begin
			num_d[k] = fill[k] * fill[CH_ALPHA] + pix[k] * ia;
		end
		num_d[CH_ALPHA] = pix[CH_ALPHA] * ia;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			px_s1  <= pix;
			sel_s1 <= selected;
			sqd_s1 <= sqd_d;
			num_s1 <= num_d;
		end
	end

	// stage 2: distance compare and divide by 255
	pixel_t      px_s2;
	pixel_t      bl_s2;
	logic        hit_s2;

	logic [17:0] dist_sum;
	logic [15:0] tsq;
	logic [17:0] thr;
	logic        degenerate;
	pixel_t      bl_d;

	assign dist_sum = {2'b00, sqd_s1[0]} + {2'b00, sqd_s1[1]}
		+ {2'b00, sqd_s1[2]} + {2'b00, sqd_s1[3]};
	assign tsq        = tol * tol;
	assign thr        = {tsq, 2'b00};
	assign degenerate = (target == fill) && (tol == 8'd0);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			bl_d[k] = div255(num_s1[k]);
		end
		bl_d[CH_ALPHA] = fill[CH_ALPHA] + div255(num_s1[CH_ALPHA]);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			px_s2  <= px_s1;
			bl_s2  <= bl_d;
			hit_s2 <= sel_s1 && !degenerate && (dist_sum <= thr);
		end
	end

	// stage 3: result select, output register
	pixel_t res_s3;
	logic   filled_s3;
	pixel_t res_d;

	always_comb begin
		res_d = px_s2;
		if (hit_s2) begin
			if (overwrite || fill[CH_ALPHA] == ALPHA_OPAQUE) begin
				res_d = fill;
			end else if (fill[CH_ALPHA] != ALPHA_CLEAR) begin
				res_d = bl_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			res_s3    <= res_d;
			filled_s3 <= hit_s2;
		end
	end

	assign res    = res_s3;
	assign filled = filled_s3;

endmodule

// ===== rtl/global_tolerance_color_fill_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// global_tolerance_color_fill_core
// Tolerance color match and fill/blend over a BGRA pixel stream.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// pixel in  in_valid / in_ready    in_blue, in_green, in_red, in_alpha, in_selected
// pixel out out_valid / out_ready  out_blue, out_green, out_red, out_alpha, was_filled
// config    cfg_write              cfg_index, cfg_data
//
// One pixel per clock sustained while out_ready holds; the stages are products, compare
// and divide, and result mux. Each stage advances when it is empty or the next stage
// moves, so bubbles close up behind a stalled output. Reset clears the stage
// valid bits and loads the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "global_tolerance_color_fill_core_defines.svh"

module global_tolerance_color_fill_core import gtcf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_blue,
	input  logic [7:0]            in_green,
	input  logic [7:0]            in_red,
	input  logic [7:0]            in_alpha,
	input  logic                  in_selected,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_blue,
	output logic [7:0]            out_green,
	output logic [7:0]            out_red,
	output logic [7:0]            out_alpha,
	output logic                  was_filled
);

	logic [31:0] target_q;
	logic [31:0] fill_q;
	logic [7:0]  tol_q;
	logic        overwrite_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			fill_q      <= '0;
			tol_q       <= '0;
			overwrite_q <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TARGET_COLOR:   target_q    <= cfg_data;
				REG_FILL_COLOR:     fill_q      <= cfg_data;
				REG_TOLERANCE:      tol_q       <= cfg_data[7:0];
				REG_OVERWRITE_MODE: overwrite_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage valid bits and advance enables
	logic     v1_s1;
	logic     v2_s2;
	logic     v3_s3;
	pipe_en_t en;

	assign en.s3    = !v3_s3 || out_ready;
	assign en.s2    = !v2_s2 || en.s3;
	assign en.s1    = !v1_s1 || en.s2;
	assign in_ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (en.s1) v1_s1 <= in_valid;
			if (en.s2) v2_s2 <= v1_s1;
			if (en.s3) v3_s3 <= v2_s2;
		end
	end

	pixel_t pix;
	pixel_t res;

	assign pix[CH_BLUE]  = in_blue;
	assign pix[CH_GREEN] = in_green;
	assign pix[CH_RED]   = in_red;
	assign pix[CH_ALPHA] = in_alpha;

	gtcf_pipe u_pipe (
		.clk       (clk),
		.en        (en),
		.pix       (pix),
		.selected  (in_selected),
		.target    (target_q),
		.fill      (fill_q),
		.tol       (tol_q),
		.overwrite (overwrite_q),
		.res       (res),
		.filled    (was_filled)
	);

	assign out_valid = v3_s3;
	assign out_blue  = res[CH_BLUE];
	assign out_green = res[CH_GREEN];
	assign out_red   = res[CH_RED];
	assign out_alpha = res[CH_ALPHA];

	// an empty first stage must always take a transaction
	`GTCF_ASSERT_IMPL(a_empty_takes, !v1_s1, in_ready)
	// overwrite fill drives the fill color out
	`GTCF_ASSERT_IMPL(a_overwrite_fill, out_valid && was_filled && overwrite_q,
		out_blue == fill_q[7:0] && out_alpha == fill_q[31:24])
	// degenerate setup never fills
	`GTCF_ASSERT_IMPL(a_degenerate, out_valid && target_q == fill_q && tol_q == 8'd0,
		!was_filled)
	// with the middle and output stages full and the output stalled, the middle stage holds
	`GTCF_ASSERT_NEXT(a_full_hold, v2_s2 && v3_s3 && !out_ready, v2_s2)

endmodule

// ===== bench/tb_global_tolerance_color_fill_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_global_tolerance_color_fill_core
// Self-checking bench for the tolerance color fill core: streams BGRA pixels
// through directed and random register settings, predicts each output pixel and compares
// it field by field, with random stalls on both handshakes.
// ----------------------------------------------------------------------------

typedef struct packed {
	gtcf_pkg::pixel_t color;
	logic             filled;
} fill_result_t;

class fill_scoreboard;
	logic [31:0] target_color;
	logic [31:0] fill_color;
	logic [7:0]  tolerance;
	logic        overwrite;
	fill_result_t expected_pixels[$];
	string chan_names[4] = '{"blue", "green", "red", "alpha"};
	int mismatches;
	int pixels_in;
	int pixels_filled;
	int blend_fills;

	function new();
		target_color  = '0;
		fill_color    = '0;
		tolerance     = '0;
		overwrite     = 1'b1;
		mismatches    = 0;
		pixels_in     = 0;
		pixels_filled = 0;
		blend_fills   = 0;
	endfunction

	function void write_reg(logic [gtcf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		case (idx)
			gtcf_pkg::REG_TARGET_COLOR:   target_color = data;
			gtcf_pkg::REG_FILL_COLOR:     fill_color = data;
			gtcf_pkg::REG_TOLERANCE:      tolerance = data[7:0];
			gtcf_pkg::REG_OVERWRITE_MODE: overwrite = data[0];
			default: ;
		endcase
	endfunction

	function fill_result_t fill_pixel(gtcf_pkg::pixel_t px, logic sel);
		fill_result_t r;
		gtcf_pkg::pixel_t tc;
		gtcf_pkg::pixel_t fc;
		int unsigned dist_sum;
		int unsigned d;
		int unsigned a;
		int unsigned inv;
		int unsigned tol;
		logic hit;
		tc = target_color;
		fc = fill_color;
		tol = tolerance;
		dist_sum = 0;
		for (int k = 0; k < 4; k++) begin
			d = (px[k] >= tc[k]) ? px[k] - tc[k] : tc[k] - px[k];
			dist_sum += d * d;
		end
		// target == fill with zero tolerance would be a no-op fill
		hit = sel && !(target_color == fill_color && tol == 0) && dist_sum <= tol * tol * 4;
		r.color = px;
		r.filled = hit;
		if (hit) begin
			a = fc[gtcf_pkg::CH_ALPHA];
			if (overwrite || a == gtcf_pkg::ALPHA_OPAQUE) begin
				r.color = fc;
			end else if (a != gtcf_pkg::ALPHA_CLEAR) begin
				inv = gtcf_pkg::ALPHA_OPAQUE - a;
				for (int k = 0; k < 3; k++)
					r.color[k] = 8'((fc[k] * a + px[k] * inv) / 255);
				r.color[gtcf_pkg::CH_ALPHA] = 8'(a + px[gtcf_pkg::CH_ALPHA] * inv / 255);
			end
			// clear fill alpha in blend mode leaves the pixel as is, still flagged
		end
		return r;
	endfunction

	function void note_pixel(gtcf_pkg::pixel_t px, logic sel);
		fill_result_t r;
		r = fill_pixel(px, sel);
		expected_pixels.push_back(r);
		pixels_in++;
		if (r.filled) begin
			pixels_filled++;
			if (!overwrite)
				blend_fills++;
		end
	endfunction

	function void check_pixel(gtcf_pkg::pixel_t got, logic got_filled);
		fill_result_t want;
		if (expected_pixels.size() == 0) begin
			$display("%0t: output pixel %h filled=%b with no transaction pending",
				$time, got, got_filled);
			mismatches++;
			return;
		end
		want = expected_pixels.pop_front();
		for (int k = 0; k < 4; k++) begin
			if (got[k] !== want.color[k]) begin
				$display("%0t: %s expected %0d actual %0d", $time, chan_names[k],
					want.color[k], got[k]);
				mismatches++;
			end
		end
		if (got_filled !== want.filled) begin
			$display("%0t: was_filled expected %b actual %b", $time, want.filled, got_filled);
			mismatches++;
		end
	endfunction

	function int pending();
		return expected_pixels.size();
	endfunction
endclass

module tb_global_tolerance_color_fill_core;
	import gtcf_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PIPE_DEPTH  = 3;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            in_blue = '0;
	logic [7:0]            in_green = '0;
	logic [7:0]            in_red = '0;
	logic [7:0]            in_alpha = '0;
	logic                  in_selected = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            out_blue;
	logic [7:0]            out_green;
	logic [7:0]            out_red;
	logic [7:0]            out_alpha;
	logic                  was_filled;

	fill_scoreboard sb = new();

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_stall_left = 0;
	int cycle_count = 0;
	int settings_count = 0;

	global_tolerance_color_fill_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding",
				cycle_count, sb.pending());
			$display("TB_ERROR");
			$finish;
		end
	end

	// transaction monitor: both channels sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_pixel({in_alpha, in_red, in_green, in_blue}, in_selected);
			if (out_valid && out_ready)
				sb.check_pixel({out_alpha, out_red, out_green, out_blue}, was_filled);
		end
	end

	// mostly short gaps, a few long ones
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(1, 3);
		else if (r < 9)
			return $urandom_range(4, 8);
		return $urandom_range(20, 50);
	endfunction

	always @(negedge clk) begin
		if (rx_stall_left > 0) begin
			out_ready <= 1'b0;
			rx_stall_left--;
		end else if (arst_n && rx_idle_on && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			rx_stall_left = idle_length() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// called at a falling edge; returns at a falling edge with valid left high
	// only when no gap follows
	task automatic send_pixel(input logic [31:0] px, input logic sel);
		int gap;
		in_blue     <= px[7:0];
		in_green    <= px[15:8];
		in_red      <= px[23:16];
		in_alpha    <= px[31:24];
		in_selected <= sel;
		in_valid    <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? idle_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_fill(input logic [31:0] target, input logic [31:0] fill,
		input logic [31:0] tol_word, input logic [31:0] mode_word);
		write_reg(REG_TARGET_COLOR, target);
		write_reg(REG_FILL_COLOR, fill);
		write_reg(REG_TOLERANCE, tol_word);
		write_reg(REG_OVERWRITE_MODE, mode_word);
		settings_count++;
	endtask

	task automatic directed_pixels();
		// reset defaults: target == fill, zero tolerance -> nothing fills
		send_pixel(32'h00000000, 1'b1);
		send_pixel(32'hFFFFFFFF, 1'b1);
		wait_idle();
		// exact match only, overwrite
		program_fill(32'h80402010, 32'hC0112233, 32'd0, 32'd1);
		send_pixel(32'h80402010, 1'b1);
		send_pixel(32'h80402010, 1'b0);
		send_pixel(32'h80402011, 1'b1);
		wait_idle();
		// widest tolerance covers every color
		program_fill(32'h80402010, 32'hC0112233, 32'd255, 32'd1);
		send_pixel(32'h00000000, 1'b1);
		send_pixel(32'hFFFFFFFF, 1'b1);
		send_pixel(32'h00000000, 1'b0);
		wait_idle();
		// blend with partial fill alpha
		program_fill(32'h80402010, 32'hC0112233, 32'd255, 32'd0);
		send_pixel(32'h00FFFFFF, 1'b1);
		send_pixel(32'hFF000000, 1'b1);
		send_pixel(32'h7F7F7F7F, 1'b1);
		wait_idle();
		// clear fill in blend mode: pixel unchanged but flagged
		program_fill(32'h80402010, 32'h00ABCDEF, 32'd255, 32'd0);
		send_pixel(32'h12345678, 1'b1);
		send_pixel(32'hFFFFFFFF, 1'b1);
		wait_idle();
		// opaque fill in blend mode acts as overwrite
		program_fill(32'h80402010, 32'hFF5A5A5A, 32'd255, 32'd0);
		send_pixel(32'h01020304, 1'b1);
		send_pixel(32'hFFFFFFFF, 1'b1);
		wait_idle();
		// target == fill: degenerate at zero tolerance, live at one
		program_fill(32'h3C3C3C3C, 32'h3C3C3C3C, 32'd0, 32'd1);
		send_pixel(32'h3C3C3C3C, 1'b1);
		wait_idle();
		program_fill(32'h3C3C3C3C, 32'h3C3C3C3C, 32'd1, 32'd1);
		send_pixel(32'h3C3C3C3C, 1'b1);
		send_pixel(32'h3D3D3D3D, 1'b1);
		send_pixel(32'h3C3C3C3E, 1'b1);
		send_pixel(32'h3C3C3D3E, 1'b1);
		wait_idle();
	endtask

	task automatic random_setup(input int phase);
		logic [31:0] target;
		logic [31:0] fill;
		logic [7:0]  tol;
		logic        mode;
		target = $urandom;
		fill = $urandom;
		case ($urandom_range(0, 4))
			0: tol = 8'd0;
			1: tol = 8'd255;
			2: tol = 8'($urandom_range(1, 8));
			3: tol = 8'($urandom_range(9, 60));
			default: tol = 8'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 3))
			0: fill[31:24] = ALPHA_CLEAR;
			1: fill[31:24] = ALPHA_OPAQUE;
			default: ;
		endcase
		if ($urandom_range(0, 5) == 0)
			fill = target;
		mode = 1'($urandom_range(0, 1));
		if (phase == 0) begin
			target = 32'hFFFFFFFF;
			fill   = 32'h00000000;
			tol    = 8'd255;
			mode   = 1'b0;
		end else if (phase == 1) begin
			target = 32'h00000000;
			fill   = 32'hFFFFFFFF;
			tol    = 8'd255;
			mode   = 1'b1;
		end
		// upper data bits are don't-care for the narrow registers
		program_fill(target, fill, ($urandom & 32'hFFFFFF00) | tol,
			($urandom & 32'hFFFFFFFE) | mode);
	endtask

	// half the pixels land near the target so the fill path is exercised
	function automatic logic [31:0] random_pixel();
		logic [31:0] px;
		int lim;
		int c;
		px = $urandom;
		if ($urandom_range(0, 1) == 0) begin
			lim = sb.tolerance + $urandom_range(0, 1);
			for (int k = 0; k < 4; k++) begin
				c = sb.target_color[8*k +: 8];
				if ($urandom_range(0, 1) == 0)
					c += $urandom_range(0, lim);
				else
					c -= $urandom_range(0, lim);
				if (c < 0)
					c = 0;
				if (c > 255)
					c = 255;
				px[8*k +: 8] = 8'(c);
			end
		end
		return px;
	endfunction

	initial begin
		int hold_at;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_pixels();

		for (int phase = 0; phase < PHASES; phase++) begin
			random_setup(phase);
			tx_idle_on = (phase % 4) != 3;
			rx_idle_on = (phase % 3) != 2;
			hold_at = $urandom_range(10, PHASE_ITEMS - 10);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// let the pipeline run dry once per phase
				if (n == hold_at)
					wait_idle();
				send_pixel(random_pixel(), $urandom_range(0, 7) != 0);
			end
			wait_idle();
		end

		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		wait_idle();
		repeat (10) @(negedge clk);

		$display("%0d pixels over %0d register settings: %0d filled, %0d of them blended",
			sb.pixels_in, settings_count, sb.pixels_filled, sb.blend_fills);
		$display("%0d mismatches, %0d pixels still outstanding", sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
